// ===== hw/rtl/mts_pkg.sv =====
// Shared constants and types for the min-tracking stack.
package mts_pkg;

    // Stack geometry and data width
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int WORD_W     = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int OUT_CNT_W  = 7;
    localparam int ENTRY_W    = 2 * DATA_WIDTH;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic signed [WORD_W-1:0]     t_word;
    typedef logic [CNT_W-1:0]             t_count;
    typedef logic [ADDR_W-1:0]            t_addr;

    // Operation codes
    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

endpackage

// ===== hw/rtl/mts_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered read data.
module mts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/min_tracking_stack.sv =====
// Stack of signed values that tracks the running minimum: controller and entry memory.
//
// Usage: one input channel (i_valid/o_ready) carries a word with i_cmd (push or
// pop) and i_push_value. One output channel (o_valid/i_ready) returns one word
// per input: the new top value, the stack minimum, the entry count, an empty
// flag and a status (ok, push dropped when full, pop on empty ignored).
// Each entry in the memory holds the value and the minimum at or below it;
// the current top entry is also kept in registers.
// Timing: a push, a dropped push, a pop on empty and a pop that leaves the
// stack empty return their word in the cycle after acceptance. A pop that leaves
// entries behind must fetch the new top from the registered memory read, and
// its word is registered from that read data in the state ST_READ.
// Throughput: one word every cycle for pushes and short pops while the receiver
// does not stall; a pop that reads the memory holds off the next word in ST_READ.
// A new word is taken while the previous result is being taken by the receiver.
// Reset clears the entry count and the output valid; memory contents are not
// cleared. When the receiver stalls, the result is held and o_ready stays low.
module min_tracking_stack
    import mts_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_cmd,
    input  logic signed [WORD_W-1:0] i_push_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [WORD_W-1:0] o_top_value,
    output logic signed [WORD_W-1:0] o_min_value,
    output logic [OUT_CNT_W-1:0]     o_entry_count,
    output logic                     o_is_empty,
    output logic [1:0]               o_status
);

    // Control state
    t_state  r_state, n_state;
    t_count  r_count, n_count;
    logic    r_out_valid, n_out_valid;

    // Top entry and result registers
    t_data   r_top_val, n_top_val;
    t_data   r_top_min, n_top_min;
    t_word   r_out_top, n_out_top;
    t_word   r_out_min, n_out_min;
    t_count  r_out_count, n_out_count;
    logic    r_out_empty, n_out_empty;
    t_status r_out_status, n_out_status;

    // Memory ports
    logic                ram_wr_en;
    t_addr               ram_wr_addr;
    logic [ENTRY_W-1:0]  ram_wr_data;
    logic                ram_rd_en;
    t_addr               ram_rd_addr;
    logic [ENTRY_W-1:0]  ram_rd_data;

    logic    out_free;
    logic    accept;
    logic    is_full;
    t_data   push_data;
    t_data   push_min;
    t_data   rd_val;
    t_data   rd_min;

    assign out_free  = !r_out_valid || i_ready;
    assign accept    = i_valid && o_ready;
    assign is_full   = (r_count == t_count'(DEPTH));
    assign push_data = t_data'(i_push_value[DATA_WIDTH-1:0]);
    assign rd_val    = t_data'(ram_rd_data[ENTRY_W-1:DATA_WIDTH]);
    assign rd_min    = t_data'(ram_rd_data[DATA_WIDTH-1:0]);

    // Running minimum for a push: new value against the current top minimum
    always_comb begin
        if (r_count != '0 && r_top_min < push_data) begin
            push_min = r_top_min;
        end else begin
            push_min = push_data;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && t_cmd'(i_cmd) == CMD_POP && r_count > t_count'(1)) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Handshake and memory control
    always_comb begin
        o_ready     = 1'b0;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        ram_wr_addr = r_count[ADDR_W-1:0];
        ram_wr_data = {push_data, push_min};
        ram_rd_addr = t_addr'(r_count - t_count'(2));
        unique case (r_state)
            ST_IDLE: begin
                o_ready   = out_free;
                ram_wr_en = accept && t_cmd'(i_cmd) == CMD_PUSH && !is_full;
                ram_rd_en = accept && t_cmd'(i_cmd) == CMD_POP && r_count > t_count'(1);
            end
            ST_READ: begin
                o_ready = 1'b0;
            end
            default: o_ready = 1'b0;
        endcase
    end

    // Datapath: count, top registers and result word
    always_comb begin
        n_count      = r_count;
        n_top_val    = r_top_val;
        n_top_min    = r_top_min;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_top    = r_out_top;
        n_out_min    = r_out_min;
        n_out_count  = r_out_count;
        n_out_empty  = r_out_empty;
        n_out_status = r_out_status;
        if (r_state == ST_READ) begin
            // New top arrives from memory
            n_top_val    = rd_val;
            n_top_min    = rd_min;
            n_out_valid  = 1'b1;
            n_out_top    = t_word'(rd_val);
            n_out_min    = t_word'(rd_min);
            n_out_count  = r_count;
            n_out_empty  = 1'b0;
            n_out_status = STAT_OK;
        end else if (accept) begin
            if (t_cmd'(i_cmd) == CMD_PUSH) begin
                if (is_full) begin
                    n_out_valid  = 1'b1;
                    n_out_top    = t_word'(r_top_val);
                    n_out_min    = t_word'(r_top_min);
                    n_out_count  = r_count;
                    n_out_empty  = 1'b0;
                    n_out_status = STAT_FULL;
                end else begin
                    n_count      = r_count + t_count'(1);
                    n_top_val    = push_data;
                    n_top_min    = push_min;
                    n_out_valid  = 1'b1;
                    n_out_top    = t_word'(push_data);
                    n_out_min    = t_word'(push_min);
                    n_out_count  = r_count + t_count'(1);
                    n_out_empty  = 1'b0;
                    n_out_status = STAT_OK;
                end
            end else if (r_count == '0) begin
                n_out_valid  = 1'b1;
                n_out_top    = '0;
                n_out_min    = '0;
                n_out_count  = '0;
                n_out_empty  = 1'b1;
                n_out_status = STAT_EMPTY;
            end else if (r_count == t_count'(1)) begin
                n_count      = '0;
                n_out_valid  = 1'b1;
                n_out_top    = '0;
                n_out_min    = '0;
                n_out_count  = '0;
                n_out_empty  = 1'b1;
                n_out_status = STAT_OK;
            end else begin
                // Result follows once the memory read returns
                n_count = r_count - t_count'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_top_val    <= n_top_val;
        r_top_min    <= n_top_min;
        r_out_top    <= n_out_top;
        r_out_min    <= n_out_min;
        r_out_count  <= n_out_count;
        r_out_empty  <= n_out_empty;
        r_out_status <= n_out_status;
    end

    // Entry memory: {value, minimum at or below}
    mts_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (ram_wr_en),
        .i_wr_addr(ram_wr_addr),
        .i_wr_data(ram_wr_data),
        .i_rd_en  (ram_rd_en),
        .i_rd_addr(ram_rd_addr),
        .o_rd_data(ram_rd_data)
    );

    assign o_valid       = r_out_valid;
    assign o_top_value   = r_out_top;
    assign o_min_value   = r_out_min;
    assign o_entry_count = OUT_CNT_W'(r_out_count);
    assign o_is_empty    = r_out_empty;
    assign o_status      = r_out_status;

endmodule

// ===== hw/rtl/mts_checker.sv =====
// Port-level assertions for the min-tracking stack, bound to the top level.
module mts_checker
    import mts_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_ready,
    input logic                     i_cmd,
    input logic signed [WORD_W-1:0] i_push_value,
    input logic                     o_valid,
    input logic                     i_ready,
    input logic signed [WORD_W-1:0] o_top_value,
    input logic signed [WORD_W-1:0] o_min_value,
    input logic [OUT_CNT_W-1:0]     o_entry_count,
    input logic                     o_is_empty,
    input logic [1:0]               o_status
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_top_value) && $stable(o_min_value)
            && $stable(o_entry_count) && $stable(o_status))
        else $error("result word changed while stalled");

    // Empty flag agrees with the count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_entry_count == '0)))
        else $error("empty flag disagrees with entry count");

    // Empty stack reads zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_empty |-> o_top_value == '0 && o_min_value == '0)
        else $error("empty stack reports nonzero top or minimum");

    // Minimum never exceeds the top value
    a_min_le_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_empty |-> o_min_value <= o_top_value)
        else $error("minimum above top value");

    // A dropped push only happens on a full stack
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STAT_FULL |-> o_entry_count == OUT_CNT_W'(DEPTH))
        else $error("full status with stack not full");

endmodule

bind min_tracking_stack mts_checker u_mts_checker (.*);

// ===== tb/tb_min_tracking_stack.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the min-tracking stack: directed, fill/drain, random and stall tests.
module tb_min_tracking_stack;
    import mts_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_LEN   = 7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 8;
    localparam int PRINT_MAX   = 40;

    // One result word as the block should return it
    typedef struct packed {
        t_word                top;
        t_word                least;
        logic [OUT_CNT_W-1:0] count;
        logic                 empty;
        t_status              status;
    } t_stack_word;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_valid      = 1'b0;
    logic                     o_ready;
    logic                     i_cmd        = CMD_PUSH;
    t_word                    i_push_value = '0;
    logic                     o_valid;
    logic                     i_ready      = 1'b0;
    t_word                    o_top_value;
    t_word                    o_min_value;
    logic [OUT_CNT_W-1:0]     o_entry_count;
    logic                     o_is_empty;
    logic [1:0]               o_status;

    // Predicted stack contents: value and minimum at or below each entry
    t_data val_mem [DEPTH];
    t_data min_mem [DEPTH];
    int    fill_level = 0;

    t_stack_word expected_words [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    min_tracking_stack u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_push_value  (i_push_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_top_value   (o_top_value),
        .o_min_value   (o_min_value),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_status      (o_status)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Apply one operation to the predicted stack and return the word it yields
    function automatic t_stack_word apply_stack_op(input t_cmd cmd, input t_word word);
        t_stack_word res;
        t_data       v;
        t_data       m;
        res        = '0;
        res.status = STAT_OK;
        if (cmd == CMD_PUSH) begin
            if (fill_level >= DEPTH) begin
                res.status = STAT_FULL;
            end else begin
                v = t_data'(word[DATA_WIDTH-1:0]);
                m = v;
                if (fill_level > 0 && min_mem[fill_level-1] < v)
                    m = min_mem[fill_level-1];
                val_mem[fill_level] = v;
                min_mem[fill_level] = m;
                fill_level++;
            end
        end else if (fill_level == 0) begin
            res.status = STAT_EMPTY;
        end else begin
            fill_level--;
        end
        if (fill_level > 0) begin
            res.top   = t_word'(val_mem[fill_level-1]);
            res.least = t_word'(min_mem[fill_level-1]);
        end
        res.count = OUT_CNT_W'(fill_level);
        res.empty = (fill_level == 0);
        return res;
    endfunction

    // Mix of full-range, small, near-zero and extreme values
    function automatic t_word pick_value();
        int k;
        case ($urandom_range(9))
            0, 1, 2, 3: return t_word'($urandom);
            4, 5: begin
                k = $urandom_range(16);
                return t_word'(k - 8);
            end
            6: begin
                case ($urandom_range(3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: begin
                k = $urandom_range(2000);
                return t_word'(k - 1000);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_MAX)
            $display("mismatch on %s: got %0h, want %0h (cycle %0d)",
                     field, got, want, cycle_count);
    endtask

    // Offer one word, hold it until accepted, then log its expected result
    task automatic send_word(input t_cmd cmd, input t_word word);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_push_value <= word;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        expected_words.push_back(apply_stack_op(cmd, word));
    endtask

    task automatic push_word(input t_word word);
        send_word(CMD_PUSH, word);
    endtask

    // Payload on a pop is random: the block must ignore it
    task automatic pop_word();
        send_word(CMD_POP, t_word'($urandom));
    endtask

    // Extremes, equal minimum, pop on empty, unwind to empty
    task automatic test_directed();
        pop_word();
        push_word(32'sd5);
        push_word(32'sd5);
        push_word(32'sd7);
        push_word(32'h7FFF_FFFF);
        push_word(32'h8000_0000);
        push_word('0);
        push_word('1);
        push_word(32'h5555_5555);
        push_word(32'hAAAA_AAAA);
        repeat (9) pop_word();
        pop_word();
    endtask

    // Fill past full so pushes get dropped, then drain past empty
    task automatic test_fill_drain();
        for (int i = 0; i < DEPTH + 3; i++)
            push_word(pick_value());
        repeat (DEPTH + 2) pop_word();
    endtask

    // Bursts biased up, down or balanced so the stack swings between empty and full
    task automatic test_random(input int n_items);
        int sent;
        int burst;
        int push_pct;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(60, 10);
            case ($urandom_range(2))
                0:       push_pct = 90;
                1:       push_pct = 15;
                default: push_pct = 50;
            endcase
            repeat (burst) begin
                if ($urandom_range(99) < push_pct)
                    push_word(pick_value());
                else
                    pop_word();
            end
            sent += burst;
        end
    endtask

    // Receiver holds off for a long stretch while words keep coming
    task automatic test_backpressure();
        hold_left = 300;
        repeat (80) begin
            if ($urandom_range(99) < 60)
                push_word(pick_value());
            else
                pop_word();
        end
    endtask

    // Receiver ready: long hold when requested, else random stalls
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin : check_words
        t_stack_word want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", o_top_value, '0);
            end else begin
                want = expected_words.pop_front();
                if (o_top_value !== want.top)
                    report_mismatch("top_value", o_top_value, want.top);
                if (o_min_value !== want.least)
                    report_mismatch("min_value", o_min_value, want.least);
                if (o_entry_count !== want.count)
                    report_mismatch("entry_count", 32'(o_entry_count), 32'(want.count));
                if (o_is_empty !== want.empty)
                    report_mismatch("is_empty", 32'(o_is_empty), 32'(want.empty));
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_min_tracking_stack: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct  = 32;
        recv_stall_pct = 59;
        test_directed();
        test_fill_drain();
        test_random(550);
        test_backpressure();

        send_idle_pct  = 59;
        recv_stall_pct = 32;
        test_random(550);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random(550);

        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("tb_min_tracking_stack: PASS");
        else
            $display("tb_min_tracking_stack: FAIL");
        $finish;
    end

endmodule
